// ----- rtl/sgr_pkg.sv -----
// Shared types and state codes for the stream group reverser.
// No dependencies; compile first.
`default_nettype none

package sgr_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned GroupSizeW = 5;

  typedef logic [GroupSizeW-1:0] group_size_t;

  typedef struct packed {
    logic signed [ValueW-1:0] elem_value;
    logic                     final_elem;
  } in_item_t;

  typedef struct packed {
    logic signed [ValueW-1:0] out_value;
    logic                     run_last;
    logic                     list_end;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;  // store the accepted element, set up emission if due
    logic step;  // read one buffer entry into the output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic go_emit;    // the element at the input closes a group or the list
    logic last_step;  // one result left in the current group
    logic out_free;   // output register can take a new result this cycle
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/sgr_stream_if.sv -----
// Valid/ready channel interface carrying one payload of type T.
// Used by the stream group reverser for configuration, input and output.
`default_nettype none

interface sgr_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

`default_nettype wire

// ----- rtl/sgr_ctrl.sv -----
// Control state machine of the stream group reverser.
// Depends on sgr_pkg; drives commands into sgr_datapath.
`default_nettype none

module sgr_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  sgr_pkg::dp_status_t status_i,
  output sgr_pkg::dp_cmd_t    cmd_o
);
  import sgr_pkg::*;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        if (in_valid_i && status_i.go_emit) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        // advance one result whenever the output register has room
        if (status_i.out_free) begin
          cmd_o.step = 1'b1;
          if (status_i.last_step) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sgr_datapath.sv -----
// Datapath of the stream group reverser: group buffer, counters,
// group size register and output register. Depends on sgr_pkg.
`default_nettype none

module sgr_datapath #(
  parameter int unsigned MAX_GROUP = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_valid_i,
  input  sgr_pkg::group_size_t cfg_data_i,
  input  sgr_pkg::in_item_t    in_data_i,
  input  sgr_pkg::dp_cmd_t     cmd_i,
  output sgr_pkg::dp_status_t  status_o,
  input  wire                  out_ready_i,
  output logic                 out_valid_o,
  output sgr_pkg::out_item_t   out_data_o
);
  import sgr_pkg::*;

  localparam int unsigned CntW  = $clog2(MAX_GROUP + 1);
  localparam int unsigned AddrW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

  logic signed [ValueW-1:0] buf_mem [MAX_GROUP];

  group_size_t      group_size_q;
  logic [CntW-1:0]  fill_q, fill_d;
  logic [AddrW-1:0] idx_q;
  logic [CntW-1:0]  left_q;
  logic             rev_q;
  logic             fin_q;
  logic             out_valid_q;
  out_item_t        out_data_q;

  logic [CntW-1:0]  eff_size;
  logic [CntW-1:0]  held_cnt;
  logic             full_group;

  // group size zero acts as one, sizes beyond the buffer clamp to its depth
  always_comb begin
    if (group_size_q == '0) begin
      eff_size = CntW'(1);
    end else if (int'(group_size_q) > int'(MAX_GROUP)) begin
      eff_size = CntW'(MAX_GROUP);
    end else begin
      eff_size = CntW'(group_size_q);
    end
  end

  assign held_cnt   = fill_q + CntW'(1);
  assign full_group = (held_cnt >= eff_size);

  assign status_o.go_emit   = full_group || in_data_i.final_elem;
  assign status_o.last_step = (left_q == CntW'(1));
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.load) begin
      fill_d = status_o.go_emit ? '0 : held_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q <= group_size_t'(1);
      fill_q       <= '0;
      left_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        group_size_q <= cfg_data_i;
      end
      fill_q <= fill_d;
      if (cmd_i.load && status_o.go_emit) begin
        left_q <= held_cnt;
      end else if (cmd_i.step) begin
        left_q <= left_q - CntW'(1);
      end
      if (cmd_i.step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // buffer write, registered read into the output register, walk pointers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      buf_mem[fill_q[AddrW-1:0]] <= in_data_i.elem_value;
      if (status_o.go_emit) begin
        rev_q <= full_group;
        fin_q <= in_data_i.final_elem;
        idx_q <= full_group ? fill_q[AddrW-1:0] : '0;
      end
    end
    if (cmd_i.step) begin
      out_data_q.out_value <= buf_mem[idx_q];
      out_data_q.run_last  <= status_o.last_step;
      out_data_q.list_end  <= status_o.last_step && fin_q;
      idx_q                <= rev_q ? (idx_q - AddrW'(1)) : (idx_q + AddrW'(1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ----- rtl/stream_group_reverser.sv -----
// Stream group reverser: reverses signed values in full groups of group_size.
// After a closing element is accepted, the controller enters S_EMIT, and each step then reads one
// buffer entry into the output register, one read per result; output stalls hold emission.
// An element that closes nothing is only stored; no element is accepted while a group is emitted.
// Reset: fill count 0, group size 1, output empty; buffer contents undefined until written.
`default_nettype none

module stream_group_reverser #(
  parameter int unsigned MAX_GROUP = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  sgr_stream_if.sink   cfg_ch,
  sgr_stream_if.sink   in_ch,
  sgr_stream_if.source out_ch
);
  import sgr_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;
  logic       in_ready;

  // The group size register takes a write in any cycle; the user writes it
  // only while no transaction is in flight.
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  // Controller: accepts elements in idle; once one closes a group or the list, it steps
  // through the buffer one result per cycle while the output register has room.
  sgr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ready),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  // Datapath: group buffer memory, fill and walk counters, output register.
  // A full group is read back from the newest entry down; a partial group
  // flushed by the final element is read back from entry 0 up.
  sgr_datapath #(
    .MAX_GROUP (MAX_GROUP)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_ch.valid),
    .cfg_data_i  (cfg_ch.data),
    .in_data_i   (in_ch.data),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .out_ready_i (out_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_data_o  (out_ch.data)
  );

  // Hold off new elements while a group is being emitted.
  a_no_accept_while_emit: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.step |-> !in_ch.ready
  ) else $error("input ready while emitting a group");

  // A transaction that closes a group or the list moves the block out of idle.
  a_emit_follows_close: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready && dp_status.go_emit) |=> !in_ch.ready
  ) else $error("group close did not start emission");

  // The end of the list is always the last result of its item.
  a_list_end_is_run_last: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.data.list_end) |-> out_ch.data.run_last
  ) else $error("list_end without run_last");

endmodule

`default_nettype wire
